[src/pbsc_pkg.sv]
package pbsc_pkg;

  localparam int BUDGET_W = 18;
  localparam int TARGET_W = 7;
  localparam int OUT_W    = 15;
  localparam int CNT_W    = 16;
  localparam int RATED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int CLAMP_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W   = 40;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 16;
  localparam int GAIN_FRAC = 12;

  localparam logic [MUL_B_W-1:0] PCT_SCALE = MUL_B_W'(100);

  localparam logic [RATED_W-1:0] RATED_RST   = RATED_W'(2000);
  localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(4096);
  localparam logic [CLAMP_W-1:0] CLAMP_RST   = CLAMP_W'(10);
  localparam logic [CNT_W-1:0]   TIMEOUT_RST = CNT_W'(300);
  localparam logic [CNT_W-1:0]   RECOVER_RST = CNT_W'(300);

  localparam logic [CFG_IDX_W-1:0] REG_PERCENT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATED_POWER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CLAMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY     = 3'd6;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SCALE = 6'b000100,
    S_DIV   = 6'b001000,
    S_WAIT  = 6'b010000,
    S_UPD   = 6'b100000
  } pbsc_state_t;

endpackage

[src/pbsc_div.sv]
module pbsc_div
  import pbsc_pkg::*;
#(
  parameter int DW = 36
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [RATED_W-1:0] divisor,
  output logic               busy,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [RATED_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [RATED_W-1:0] dvs_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [RATED_W:0]   shifted;
  logic [RATED_W:0]   trial;

  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    trial    = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[RATED_W]) begin
        rem_nxt = trial[RATED_W-1:0];
      end else begin
        rem_nxt = shifted[RATED_W-1:0];
      end
      quo_nxt  = {quo_r[DW-2:0], ~trial[RATED_W]};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[src/power_budget_step_controller.sv]
// Power budget step controller.
// Input channel (in_valid/in_ready): one transaction per control tick with the
// surplus power budget, the percent target, the enable and the fresh flag.
// Output channel (out_valid/out_ready): one transaction per tick with the new
// output percentage (Q7.8 by default), a changed flag and the watchdog flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock
// edge; write only while no tick is in flight.
// Each tick runs from acceptance through the states S_MUL, S_SCALE, S_DIV and
// S_WAIT to S_UPD, which commits it and raises out_valid: two passes through one shared
// multiplier (gain by budget, then by 100) and a one-bit-per-cycle restoring
// divide by the rated power. in_ready is high only while the sequencer is idle,
// so a new tick is accepted only after the last one has committed.
// The result sits in an output register; the next tick is accepted while it
// waits. If the receiver stalls with a result still held, the next tick
// finishes its arithmetic and holds before committing state.
// Reset (rst_n low, synchronous) zeroes the internal current percentage and both
// watchdog counters and loads the register defaults.
module power_budget_step_controller
  import pbsc_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BUDGET_W-1:0]    in_power_budget_watts,
  input  logic [TARGET_W-1:0]    in_target_percent,
  input  logic                   in_ctrl_enable,
  input  logic                   in_budget_fresh,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       out_output_percent,
  output logic                   out_output_changed,
  output logic                   out_watchdog_holding,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PCTW = 7 + FRACTION_BITS;
  localparam int NW   = PCTW + 2;
  localparam int DW   = PROD_W + FRACTION_BITS - GAIN_FRAC;
  localparam int EXTW = (PCTW > OUT_W) ? PCTW : OUT_W;
  localparam logic [PCTW-1:0] ONE_Q  = PCTW'(1) << FRACTION_BITS;
  localparam logic [PCTW-1:0] FULL_Q = PCTW'(100) << FRACTION_BITS;

  logic                 pct_mode_r;
  logic [RATED_W-1:0]   rated_r;
  logic [CNT_W-1:0]     margin_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [CLAMP_W-1:0]   clamp_r;
  logic [CNT_W-1:0]     timeout_r;
  logic [CNT_W-1:0]     recovery_r;

  pbsc_state_t          state_r, state_nxt;
  logic [PCTW-1:0]      cur_r;
  logic [CNT_W-1:0]     wd_r;
  logic [CNT_W-1:0]     rc_r;

  logic signed [BUDGET_W-1:0] budget_r;
  logic [TARGET_W-1:0]  target_r;
  logic                 enable_r;
  logic                 fresh_r;
  logic [PROD_W-1:0]    prod_r;

  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_pct_r;
  logic                 out_chg_r;
  logic                 out_hold_r;

  logic [BUDGET_W-1:0]  mag;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] mul_p;
  logic [PROD_W+FRACTION_BITS-1:0] num;

  logic                 dv_start;
  logic                 dv_busy;
  logic [DW-1:0]        dv_q;

  logic                 commit;
  logic [CNT_W-1:0]     wd_base, wd_nxt;
  logic [CNT_W-1:0]     rc_nxt;
  logic [PCTW-1:0]      clamp_q;
  logic [PCTW-1:0]      tgt_q;
  logic [PCTW-1:0]      step_mag;
  logic signed [NW-1:0] cur_s, step_s, next_s;
  logic [PCTW-1:0]      next_pct;
  logic [EXTW-1:0]      next_ext;
  logic signed [BUDGET_W:0] b_ext, m_ext;
  logic                 outside;

  assign in_ready = (state_r == S_IDLE);
  assign commit   = (state_r == S_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    mag   = budget_r[BUDGET_W-1] ? BUDGET_W'(-budget_r) : BUDGET_W'(budget_r);
    mul_a = (state_r == S_MUL) ? MUL_A_W'(mag) : prod_r[MUL_A_W-1:0];
    mul_b = (state_r == S_MUL) ? gain_r : PCT_SCALE;
    mul_p = mul_a * mul_b;
    num   = {prod_r, {FRACTION_BITS{1'b0}}};
  end

  assign dv_start = (state_r == S_DIV);

  pbsc_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (num[PROD_W+FRACTION_BITS-1:GAIN_FRAC]),
    .divisor  (rated_r),
    .busy     (dv_busy),
    .quotient (dv_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DIV;
      S_DIV:   state_nxt = S_WAIT;
      S_WAIT:  if (!dv_busy) state_nxt = S_UPD;
      S_UPD:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    wd_base = fresh_r ? '0 : wd_r;
    if (wd_base < timeout_r) begin
      wd_nxt = wd_base + CNT_W'(1);
      rc_nxt = (rc_r != '0) ? rc_r - CNT_W'(1) : rc_r;
    end else begin
      wd_nxt = wd_base;
      rc_nxt = recovery_r;
    end

    clamp_q = {clamp_r, {FRACTION_BITS{1'b0}}};
    tgt_q   = {target_r, {FRACTION_BITS{1'b0}}};
    if (rated_r == '0) begin
      step_mag = (mag == '0) ? '0 : clamp_q;
    end else if (dv_q > DW'(clamp_q)) begin
      step_mag = clamp_q;
    end else begin
      step_mag = dv_q[PCTW-1:0];
    end
    step_s = budget_r[BUDGET_W-1] ? -NW'(step_mag) : NW'(step_mag);

    b_ext   = {budget_r[BUDGET_W-1], budget_r};
    m_ext   = (BUDGET_W+1)'(margin_r);
    outside = (b_ext > m_ext) || (b_ext < -m_ext);

    cur_s  = NW'(cur_r);
    next_s = cur_s;
    if (pct_mode_r) begin
      if (tgt_q > cur_r) begin
        next_s = cur_s + NW'(ONE_Q);
      end else if (tgt_q < cur_r) begin
        next_s = cur_s - NW'(ONE_Q);
      end
    end else if ((rc_nxt != '0) || !enable_r) begin
      if (!enable_r) begin
        rc_nxt = '0;
      end
      if (cur_r != '0) begin
        next_s = cur_s - NW'(ONE_Q);
      end
    end else if (outside) begin
      next_s = cur_s + step_s;
    end

    if (next_s > $signed(NW'(FULL_Q))) begin
      next_pct = FULL_Q;
    end else if (next_s < 0) begin
      next_pct = '0;
    end else begin
      next_pct = next_s[PCTW-1:0];
    end
    next_ext = EXTW'(next_pct);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      wd_r        <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
      pct_mode_r  <= 1'b0;
      rated_r     <= RATED_RST;
      margin_r    <= '0;
      gain_r      <= GAIN_RST;
      clamp_r     <= CLAMP_RST;
      timeout_r   <= TIMEOUT_RST;
      recovery_r  <= RECOVER_RST;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cur_r       <= next_pct;
        wd_r        <= wd_nxt;
        rc_r        <= rc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PERCENT_MODE: pct_mode_r <= cfg_wdata[0];
          REG_RATED_POWER:  rated_r    <= cfg_wdata[RATED_W-1:0];
          REG_MARGIN:       margin_r   <= cfg_wdata[CNT_W-1:0];
          REG_ERROR_GAIN:   gain_r     <= cfg_wdata[GAIN_W-1:0];
          REG_STEP_CLAMP:   clamp_r    <= cfg_wdata[CLAMP_W-1:0];
          REG_TIMEOUT:      timeout_r  <= cfg_wdata[CNT_W-1:0];
          REG_RECOVERY:     recovery_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      budget_r <= in_power_budget_watts;
      target_r <= in_target_percent;
      enable_r <= in_ctrl_enable;
      fresh_r  <= in_budget_fresh;
    end
    if ((state_r == S_MUL) || (state_r == S_SCALE)) begin
      prod_r <= mul_p[PROD_W-1:0];
    end
    if (commit) begin
      out_pct_r  <= next_ext[OUT_W-1:0];
      out_chg_r  <= (next_pct != cur_r);
      out_hold_r <= (rc_nxt != '0);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_output_percent   = out_pct_r;
  assign out_output_changed   = out_chg_r;
  assign out_watchdog_holding = out_hold_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("accepted transaction did not start the sequencer");

  a_pct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= FULL_Q)
    else $error("output percentage above full scale");

  a_div_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dv_busy |-> (state_r == S_WAIT))
    else $error("divider busy outside wait state");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid)
    else $error("committed tick did not raise out_valid");
`endif

endmodule
